// File: rtl/sc2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, key codes and the set 1 key-code ROM for the scan code
// decoder.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  // Key-code words: low byte base character, next byte shifted partner,
  // upper bits mark special keys.
  localparam logic [31:0] K_ESC    = 32'h0001_0000;
  localparam logic [31:0] K_CAPS   = 32'h0002_0000;
  localparam logic [31:0] K_NUMLK  = 32'h000f_0000;
  localparam logic [31:0] K_SCRLK  = 32'h0010_0000;
  localparam logic [31:0] K_PAD    = 32'h8100_0000;
  localparam logic [31:0] K_LSHIFT = 32'h8200_0000;
  localparam logic [31:0] K_RSHIFT = 32'h8400_0000;
  localparam logic [31:0] K_LCTRL  = 32'h8800_0000;
  localparam logic [31:0] K_LALT   = 32'ha000_0000;

  // ASCII helpers
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_Z       = 8'h5a;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] CTRL_OFFSET  = 8'h40;

  // Keyboard controller command to set the LEDs
  localparam logic [7:0] CMD_SET_LEDS = 8'hed;

  // Result kinds
  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_CMD  = 1'b1
  } sc2a_kind_e;

  // Modifier and lock state
  typedef struct packed {
    logic caps_on;
    logic lshift;
    logic rshift;
    logic lctrl;
    logic lalt;
  } sc2a_mods_t;

  // Decoder verdict for one scan byte
  typedef struct packed {
    logic       emit;       // at least one result
    logic       second;     // a second result follows the first
    sc2a_kind_e kind;
    logic [7:0] value;      // first result
    logic [7:0] value2;     // second result
  } sc2a_dec_t;

  function automatic logic [31:0] fn_key(input logic [3:0] n);
    fn_key = {12'h000, 4'(n + 4'd2), 16'h0000};
  endfunction

  function automatic logic [31:0] pair(input logic [7:0] a, input logic [7:0] b);
    pair = {16'h0000, b, a};
  endfunction

  function automatic logic [31:0] pad(input logic [7:0] c);
    pad = K_PAD | {24'h000000, c};
  endfunction

  // Scan code set 1 key-code ROM, indexed by the low seven bits
  function automatic logic [31:0] key_rom(input logic [6:0] idx);
    logic [31:0] code;
    code = '0;
    unique case (idx)
      7'h01: code = K_ESC;
      7'h02: code = pair(8'h31, 8'h21);
      7'h03: code = pair(8'h32, 8'h40);
      7'h04: code = pair(8'h33, 8'h23);
      7'h05: code = pair(8'h34, 8'h24);
      7'h06: code = pair(8'h35, 8'h25);
      7'h07: code = pair(8'h36, 8'h5e);
      7'h08: code = pair(8'h37, 8'h26);
      7'h09: code = pair(8'h38, 8'h2a);
      7'h0a: code = pair(8'h39, 8'h28);
      7'h0b: code = pair(8'h30, 8'h29);
      7'h0c: code = pair(8'h2d, 8'h5f);
      7'h0d: code = pair(8'h3d, 8'h2b);
      7'h0e: code = 32'h08;          // backspace
      7'h0f: code = 32'h09;          // tab
      7'h10: code = 32'h51;
      7'h11: code = 32'h57;
      7'h12: code = 32'h45;
      7'h13: code = 32'h52;
      7'h14: code = 32'h54;
      7'h15: code = 32'h59;
      7'h16: code = 32'h55;
      7'h17: code = 32'h49;
      7'h18: code = 32'h4f;
      7'h19: code = 32'h50;
      7'h1a: code = 32'h5b;
      7'h1b: code = 32'h5d;
      7'h1c: code = 32'h0a;          // enter
      7'h1d: code = K_LCTRL;
      7'h1e: code = 32'h41;
      7'h1f: code = 32'h53;
      7'h20: code = 32'h44;
      7'h21: code = 32'h46;
      7'h22: code = 32'h47;
      7'h23: code = 32'h48;
      7'h24: code = 32'h4a;
      7'h25: code = 32'h4b;
      7'h26: code = 32'h4c;
      7'h27: code = pair(8'h3b, 8'h3a);
      7'h28: code = pair(8'h27, 8'h22);
      7'h29: code = pair(8'h60, 8'h7e);
      7'h2a: code = K_LSHIFT;
      7'h2b: code = pair(8'h5c, 8'h7c);
      7'h2c: code = 32'h5a;
      7'h2d: code = 32'h58;
      7'h2e: code = 32'h43;
      7'h2f: code = 32'h56;
      7'h30: code = 32'h42;
      7'h31: code = 32'h4e;
      7'h32: code = 32'h4d;
      7'h33: code = pair(8'h2c, 8'h3c);
      7'h34: code = pair(8'h2e, 8'h3e);
      7'h35: code = pair(8'h2f, 8'h3f);
      7'h36: code = K_RSHIFT;
      7'h37: code = pad(8'h2a);
      7'h38: code = K_LALT;
      7'h39: code = 32'h20;
      7'h3a: code = K_CAPS;
      7'h3b: code = fn_key(4'd1);
      7'h3c: code = fn_key(4'd2);
      7'h3d: code = fn_key(4'd3);
      7'h3e: code = fn_key(4'd4);
      7'h3f: code = fn_key(4'd5);
      7'h40: code = fn_key(4'd6);
      7'h41: code = fn_key(4'd7);
      7'h42: code = fn_key(4'd8);
      7'h43: code = fn_key(4'd9);
      7'h44: code = fn_key(4'd10);
      7'h45: code = K_NUMLK;
      7'h46: code = K_SCRLK;
      7'h47: code = pad(8'h37);
      7'h48: code = pad(8'h38);
      7'h49: code = pad(8'h39);
      7'h4a: code = pad(8'h2d);
      7'h4b: code = pad(8'h34);
      7'h4c: code = pad(8'h35);
      7'h4d: code = pad(8'h36);
      7'h4e: code = pad(8'h2b);
      7'h4f: code = pad(8'h31);
      7'h50: code = pad(8'h32);
      7'h51: code = pad(8'h33);
      7'h52: code = pad(8'h30);
      7'h53: code = pad(8'h2e);
      7'h57: code = fn_key(4'd11);
      7'h58: code = fn_key(4'd12);
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/sc2a_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_decode
// Combinational decode of one scan byte against the current modifier state:
// next modifier state and the results the byte causes.
// ----------------------------------------------------------------------------
module sc2a_decode
  import sc2a_pkg::*;
(
  input  logic [7:0] scan_byte_i,
  input  sc2a_mods_t mods_i,
  output sc2a_mods_t mods_o,
  output sc2a_dec_t  dec_o
);

  logic [31:0] code;
  logic        release_key;
  logic        shift;
  logic        is_letter;
  logic [7:0]  ch;
  logic        is_mod;

  assign code        = key_rom(scan_byte_i[6:0]);
  assign release_key = scan_byte_i[7];
  assign shift       = mods_i.lshift | mods_i.rshift;
  assign is_letter   = (code[31:8] == '0) && (code[7:0] >= CHAR_A) && (code[7:0] <= CHAR_Z);
  assign is_mod      = (code == K_LSHIFT) || (code == K_RSHIFT) ||
                       (code == K_LCTRL)  || (code == K_LALT);

  // Character shaping: case, shifted partner, then ctrl offset
  always_comb begin
    logic [7:0] base;
    base = '0;
    if (is_letter) begin
      base = (mods_i.lctrl || (mods_i.caps_on != shift)) ? code[7:0] : (code[7:0] ^ CASE_BIT);
    end else if (code[7:0] != '0) begin
      base = ((code[15:8] != '0) && shift) ? code[15:8] : code[7:0];
    end
    ch = mods_i.lctrl ? (base - CTRL_OFFSET) : base;
  end

  // Modifier update and result selection
  always_comb begin
    mods_o = mods_i;
    dec_o  = '{emit: 1'b0, second: 1'b0, kind: KIND_CHAR, value: ch, value2: '0};
    if (release_key) begin
      if (code == K_LSHIFT) mods_o.lshift = 1'b0;
      if (code == K_RSHIFT) mods_o.rshift = 1'b0;
      if (code == K_LCTRL)  mods_o.lctrl  = 1'b0;
      if (code == K_LALT)   mods_o.lalt   = 1'b0;
    end else if (is_mod) begin
      if (code == K_LSHIFT) mods_o.lshift = 1'b1;
      if (code == K_RSHIFT) mods_o.rshift = 1'b1;
      if (code == K_LCTRL)  mods_o.lctrl  = 1'b1;
      if (code == K_LALT)   mods_o.lalt   = 1'b1;
    end else if (code == K_CAPS) begin
      // toggle caps, send LED command then the LED mask
      mods_o.caps_on = !mods_i.caps_on;
      dec_o.emit     = 1'b1;
      dec_o.second   = 1'b1;
      dec_o.kind     = KIND_CMD;
      dec_o.value    = CMD_SET_LEDS;
      dec_o.value2   = {5'b00000, !mods_i.caps_on, 2'b00};
    end else if (!mods_i.lalt) begin
      dec_o.emit = 1'b1;
    end
  end

endmodule

// File: rtl/scan_code_to_ascii_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_code_to_ascii_decoder_unit
// Set 1 scan code to ASCII decoder with shift, ctrl, alt and caps tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: one raw scan byte per transfer (bit 7 = release).
//   Master stream m_axis_*: results. tdata is the character or controller
//   byte, tuser is the kind (0 typed character, 1 keyboard controller byte),
//   tlast marks the final result caused by one scan byte.
//   A byte is held in an input register, decoded combinationally and written
//   to the output register once the output slot is free; its first result is
//   shown from the output register. One scan byte per cycle is sustained while
//   the output is taken; a caps lock press yields two results and holds the
//   input side until the second result has moved into the output register,
//   as there is a single output register. Modifier presses, releases and other
//   presses while alt is held give no result and need no free output slot.
//   While the receiver stalls, the output register holds its transfer and
//   one more scan byte can wait in the input register; tready then drops.
//   Reset clears all modifier and caps state and empties both registers.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_decoder_unit
  import sc2a_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] scan_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] value
  output logic       m_axis_tuser_o,   // [0] kind
  output logic       m_axis_tlast_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  sc2a_mods_t mods_q, mods_d;
  sc2a_dec_t  dec;

  logic       out_valid_q;
  logic [7:0] out_value_q;
  sc2a_kind_e out_kind_q;
  logic       out_last_q;

  logic       pend_q;
  logic [7:0] pend_value_q;

  logic       out_free;
  logic       fire;

  sc2a_decode u_decode (
    .scan_byte_i (in_byte_q),
    .mods_i      (mods_q),
    .mods_o      (mods_d),
    .dec_o       (dec)
  );

  // Output slot is free when empty or being taken this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;
  // Decode stage consumes the held byte
  assign fire     = in_valid_q && !pend_q && (out_free || !dec.emit);

  assign s_axis_tready_o = !in_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Modifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q <= '0;
    end else if (fire) begin
      mods_q <= mods_d;
    end
  end

  // Output register and pending second result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (pend_q && out_free) begin
      out_valid_q <= 1'b1;
      pend_q      <= 1'b0;
    end else if (fire && dec.emit) begin
      out_valid_q <= 1'b1;
      pend_q      <= dec.second;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      out_value_q <= pend_value_q;
      out_kind_q  <= KIND_CMD;
      out_last_q  <= 1'b1;
    end else if (fire && dec.emit) begin
      out_value_q  <= dec.value;
      out_kind_q   <= dec.kind;
      out_last_q   <= !dec.second;
      pend_value_q <= dec.value2;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // A pending second result only exists behind a shown first result
  a_pend_has_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("pending result without a first result");

  // A shown non-final result always has its partner queued
  a_not_last_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> pend_q)
    else $error("non-final result without a pending partner");

  // No new byte is decoded while a second result waits
  a_no_fire_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !fire)
    else $error("decode while second result pending");

  // Typed characters are always single, final results
  a_char_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_CHAR)) |-> out_last_q)
    else $error("typed character not marked last");

  // After the pending result moves out, it is final and a command byte
  a_pend_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_free) |=> (out_valid_q && out_last_q && (out_kind_q == KIND_CMD)))
    else $error("pending result not moved correctly");

endmodule
